### src/bavg_pkg.sv
`default_nettype none

package bavg_pkg;

    localparam int CELL_W    = 32;
    localparam int OCOL_W    = 11;
    localparam int OROW_W    = 12;
    localparam int SCOL_W    = 12;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int FCT_W     = 5;
    localparam int DIM_W     = 13;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MVAL   = 3'd6;

    localparam int              PCT_FULL   = 100;
    localparam logic [CELL_W-1:0] EMPTY_MASK = '1;

    localparam logic [FCT_W-1:0] FCT_RST = 5'd2;
    localparam logic [DIM_W-1:0] WID_RST = 13'd1024;
    localparam logic [DIM_W-1:0] HGT_RST = 13'd1;
    localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

    typedef enum logic [1:0] {
        DIV_NCOLS = 2'd0,
        DIV_POS   = 2'd1,
        DIV_CELL  = 2'd2
    } t_div_op;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_NC   = 8'b0000_0010,
        S_POS  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_MAG  = 8'b0001_0000,
        S_DIVS = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic    take;
        logic    clr_dirty;
        logic    mem_upd;
        logic    mag_load;
        logic    div_start;
        t_div_op div_op;
        logic    nc_load;
        logic    pos_load;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic dirty;
        logic div_done;
        logic last;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### src/bavg_div.sv
`default_nettype none

module bavg_div
    import bavg_pkg::*;
#(
    parameter int DV_W = 41,
    parameter int DS_W = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [DV_W-1:0] i_dvd,
    input  wire logic [DS_W-1:0] i_dvs,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DV_W-1:0]      o_quo,
    output logic [DS_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(DV_W);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DV_W-1:0]   r_quo;
    logic [DS_W-1:0]   r_rem;
    logic [DS_W-1:0]   r_dvs;

    logic [DS_W:0]     w_trial;
    logic [DS_W:0]     w_diff;
    logic              w_ge;
    logic [DS_W-1:0]   n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = w_trial >= {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DS_W-1:0] : w_trial[DS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(DV_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_run) begin
            r_quo <= {r_quo[DV_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_run;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### src/bavg_dp.sv
`default_nettype none

module bavg_dp
    import bavg_pkg::*;
#(
    parameter int MAX_OUT_COLS = 2048,
    parameter int MAX_FACTOR   = 16,
    parameter int SAMPLE_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [IN_W-1:0]      i_s_tdata,
    input  wire logic                 i_m_tready,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output logic                      o_m_tvalid,
    output logic [OUT_W-1:0]          o_m_tdata,
    output logic                      o_m_tlast
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int CNT_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int DV_W   = (SUM_W + 1 > DIM_W) ? SUM_W + 1 : DIM_W;
    localparam int DS_W   = (CNT_W + 1 > FCT_W) ? CNT_W + 1 : FCT_W;
    localparam int ADDR_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
    localparam int FMAX   = (MAX_FACTOR < 31) ? MAX_FACTOR : 31;
    localparam int PH_W   = $clog2(FMAX);
    localparam int NC_LIM = (MAX_OUT_COLS < 2048) ? MAX_OUT_COLS : 2048;
    localparam int MEM_W  = SUM_W + CNT_W;

    // configuration
    logic [FCT_W-1:0]         r_fct;
    logic [DIM_W-1:0]         r_wid;
    logic [DIM_W-1:0]         r_hgt;
    logic [CELL_W-1:0]        r_fill;
    logic                     r_ign;
    logic                     r_msk;
    logic [CELL_W-1:0]        r_mval;
    logic                     r_dirty;

    // position
    logic [SCOL_W-1:0]        r_scol;
    logic [OCOL_W-1:0]        r_oc;
    logic [PH_W-1:0]          r_ph;
    logic [PH_W-1:0]          r_rib;
    logic [OROW_W-1:0]        r_brow;
    logic [SCOL_W-1:0]        r_nc;

    // item latches
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                     r_inr;
    logic                     r_first;
    logic                     r_last;
    logic [ADDR_W-1:0]        r_wa;
    logic [OCOL_W-1:0]        r_lcol;
    logic [OROW_W-1:0]        r_lrow;
    logic                     r_lfe;

    // accumulate
    logic [MEM_W-1:0]         r_mem [MAX_OUT_COLS];
    logic [MEM_W-1:0]         r_rd;
    logic signed [SUM_W-1:0]  r_acc_sum;
    logic [CNT_W-1:0]         r_acc_cnt;
    logic [SUM_W-1:0]         r_mag;
    logic                     r_neg;

    // output
    logic                     r_ovld;
    logic [CELL_W-1:0]        r_ocell;
    logic [OCOL_W-1:0]        r_ocol;
    logic [OROW_W-1:0]        r_orow;
    logic                     r_ofe;

    logic                     w_div_busy;
    logic                     w_div_done;
    logic [DV_W-1:0]          w_quo;
    logic [DS_W-1:0]          w_rem;
    logic [DV_W-1:0]          w_dvd;
    logic [DS_W-1:0]          w_dvs;

    logic                     w_row_end;
    logic                     w_band_end;
    logic                     w_ph_end;
    logic                     w_inr;
    logic                     w_first;
    logic                     w_last;
    logic                     w_fe;
    logic [FCT_W-1:0]         w_fm1;

    logic signed [CELL_W-1:0] w_s32;
    logic                     w_skip;
    logic signed [SUM_W-1:0]  w_val;
    logic signed [SUM_W-1:0]  w_base_sum;
    logic [CNT_W-1:0]         w_base_cnt;
    logic signed [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]         n_cnt;
    logic [CELL_W-1:0]        w_q32;
    logic [CELL_W-1:0]        n_cell;

    logic [FCT_W-1:0]         w_cfg_f;
    logic [DIM_W-1:0]         w_cfg_d;

    // configuration writes, clamped on entry
    always_comb begin
        w_cfg_f = i_cfg_data[FCT_W-1:0];
        w_cfg_d = i_cfg_data[DIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fct   <= FCT_RST;
            r_wid   <= WID_RST;
            r_hgt   <= HGT_RST;
            r_fill  <= '0;
            r_ign   <= 1'b0;
            r_msk   <= 1'b0;
            r_mval  <= '0;
            r_dirty <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                unique case (i_cfg_idx)
                    CFG_SCALE: begin
                        if (w_cfg_f < FCT_RST) begin
                            r_fct <= FCT_RST;
                        end else if (w_cfg_f > FCT_W'(FMAX)) begin
                            r_fct <= FCT_W'(FMAX);
                        end else begin
                            r_fct <= w_cfg_f;
                        end
                    end
                    CFG_WIDTH: begin
                        if (w_cfg_d < DIM_W'(2)) begin
                            r_wid <= DIM_W'(2);
                        end else if (w_cfg_d > DIM_MAX) begin
                            r_wid <= DIM_MAX;
                        end else begin
                            r_wid <= w_cfg_d;
                        end
                    end
                    CFG_HEIGHT: begin
                        if (w_cfg_d < DIM_W'(1)) begin
                            r_hgt <= DIM_W'(1);
                        end else if (w_cfg_d > DIM_MAX) begin
                            r_hgt <= DIM_MAX;
                        end else begin
                            r_hgt <= w_cfg_d;
                        end
                    end
                    CFG_FILL:   r_fill <= i_cfg_data[CELL_W-1:0];
                    CFG_IGNORE: r_ign  <= i_cfg_data[0];
                    CFG_MASK:   r_msk  <= i_cfg_data[0];
                    CFG_MVAL:   r_mval <= i_cfg_data[CELL_W-1:0];
                    default: ;
                endcase
            end else if (i_cmd.clr_dirty) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // position flags of the item at the head
    always_comb begin
        w_fm1      = r_fct - FCT_W'(1);
        w_row_end  = (DIM_W'(r_scol) + DIM_W'(1)) >= r_wid;
        w_band_end = (FCT_W'(r_rib) + FCT_W'(1)) >= r_fct;
        w_ph_end   = (FCT_W'(r_ph) + FCT_W'(1)) >= r_fct;
        w_inr      = SCOL_W'(r_oc) < r_nc;
        w_first    = (r_rib == '0) && (r_ph == '0);
        w_last     = w_inr && (FCT_W'(r_rib) == w_fm1) && (FCT_W'(r_ph) == w_fm1);
        w_fe       = ((DIM_W'(r_brow) + DIM_W'(1)) >= r_hgt)
                     && ((SCOL_W'(r_oc) + SCOL_W'(1)) == r_nc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_oc   <= '0;
            r_ph   <= '0;
            r_rib  <= '0;
            r_brow <= '0;
            r_nc   <= '0;
        end else begin
            if (i_cmd.nc_load) begin
                if (SCOL_W'(w_quo) > SCOL_W'(NC_LIM)) begin
                    r_nc <= SCOL_W'(NC_LIM);
                end else begin
                    r_nc <= SCOL_W'(w_quo);
                end
            end
            if (i_cmd.pos_load) begin
                r_oc <= OCOL_W'(w_quo);
                r_ph <= PH_W'(w_rem);
            end else if (i_cmd.take) begin
                if (w_row_end) begin
                    r_scol <= '0;
                    r_oc   <= '0;
                    r_ph   <= '0;
                    if (w_band_end) begin
                        r_rib <= '0;
                        if ((DIM_W'(r_brow) + DIM_W'(1)) >= r_hgt) begin
                            r_brow <= '0;
                        end else begin
                            r_brow <= r_brow + 1'b1;
                        end
                    end else begin
                        r_rib <= r_rib + 1'b1;
                    end
                end else begin
                    r_scol <= r_scol + 1'b1;
                    if (w_ph_end) begin
                        r_ph <= '0;
                        r_oc <= r_oc + 1'b1;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_smp   <= i_s_tdata[SAMPLE_BITS-1:0];
            r_inr   <= w_inr;
            r_first <= w_first;
            r_wa    <= ADDR_W'(r_oc);
            r_lcol  <= r_oc;
            r_lrow  <= r_brow;
            r_lfe   <= w_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else if (i_cmd.take) begin
            r_last <= w_last;
        end
    end

    // read-modify-write of the column entry
    always_comb begin
        w_s32      = CELL_W'(r_smp);
        w_skip     = r_ign && (w_s32 == $signed(r_fill));
        if (r_msk) begin
            w_val = (w_s32 == $signed(r_mval)) ? SUM_W'(PCT_FULL) : '0;
        end else begin
            w_val = SUM_W'(r_smp);
        end
        w_base_sum = r_first ? '0 : $signed(r_rd[MEM_W-1:CNT_W]);
        w_base_cnt = r_first ? '0 : r_rd[CNT_W-1:0];
        n_sum      = w_skip ? w_base_sum : w_base_sum + w_val;
        n_cnt      = w_skip ? w_base_cnt : w_base_cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_upd && r_inr) begin
            r_mem[r_wa] <= {n_sum, n_cnt};
        end
        r_rd <= r_mem[ADDR_W'(r_oc)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_upd) begin
            r_acc_sum <= n_sum;
            r_acc_cnt <= n_cnt;
        end
        if (i_cmd.mag_load) begin
            r_neg <= r_acc_sum[SUM_W-1];
            r_mag <= r_acc_sum[SUM_W-1] ? SUM_W'(-r_acc_sum) : SUM_W'(r_acc_sum);
        end
    end

    // shared divider: column count, position, cell average
    always_comb begin
        unique case (i_cmd.div_op)
            DIV_NCOLS: begin
                w_dvd = DV_W'(r_wid);
                w_dvs = DS_W'(r_fct);
            end
            DIV_POS: begin
                w_dvd = DV_W'(r_scol);
                w_dvs = DS_W'(r_fct);
            end
            DIV_CELL: begin
                w_dvd = DV_W'({r_mag, 1'b0}) + DV_W'(r_acc_cnt);
                w_dvs = DS_W'({r_acc_cnt, 1'b0});
            end
            default: begin
                w_dvd = DV_W'(r_wid);
                w_dvs = DS_W'(r_fct);
            end
        endcase
    end

    bavg_div #(
        .DV_W(DV_W),
        .DS_W(DS_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_dvd  (w_dvd),
        .i_dvs  (w_dvs),
        .o_busy (w_div_busy),
        .o_done (w_div_done),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    // output register
    always_comb begin
        w_q32 = CELL_W'(w_quo);
        if (r_acc_cnt == '0) begin
            n_cell = r_msk ? EMPTY_MASK : r_fill;
        end else begin
            n_cell = r_neg ? -w_q32 : w_q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ocell <= n_cell;
            r_ocol  <= r_lcol;
            r_orow  <= r_lrow;
            r_ofe   <= r_lfe;
        end
    end

    always_comb begin
        o_sts.dirty    = r_dirty;
        o_sts.div_done = w_div_done;
        o_sts.last     = r_last;
        o_sts.cnt_zero = r_acc_cnt == '0;
        o_sts.out_free = !r_ovld || i_m_tready;
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {1'b0, r_orow, r_ocol, r_ocell};
    assign o_m_tlast  = r_ofe;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovld || i_m_tready))
        else $error("output register overwritten");

    a_take_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !r_dirty)
        else $error("item taken with stale column geometry");

    a_phase_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (FCT_W'(r_ph) < r_fct))
        else $error("block phase out of range");

endmodule

`default_nettype wire

### src/bavg_ctrl.sv
`default_nettype none

module bavg_ctrl
    import bavg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire t_sts i_sts,
    output logic      o_s_tready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.dirty) begin
                    o_cmd.clr_dirty = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_NCOLS;
                    n_state         = S_NC;
                end else begin
                    o_s_tready = 1'b1;
                    if (i_s_tvalid) begin
                        o_cmd.take = 1'b1;
                        n_state    = S_RD;
                    end
                end
            end
            S_NC: begin
                o_cmd.div_op = DIV_POS;
                if (i_sts.div_done) begin
                    o_cmd.nc_load   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_POS;
                end
            end
            S_POS: begin
                if (i_sts.div_done) begin
                    o_cmd.pos_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.mem_upd = 1'b1;
                n_state       = i_sts.last ? S_MAG : S_IDLE;
            end
            S_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state        = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_op = DIV_CELL;
                if (i_sts.cnt_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/block_average_downscaler.sv
`default_nettype none

// Block-average downscaler. Source samples enter in row order on the slave
// stream; each scale_factor x scale_factor square becomes one output cell,
// the average rounded half away from zero (percentage of mask hits in mask
// mode), carrying its column and row, with tlast on the last cell of the
// frame. Partial blocks at the right edge are dropped. Per-column sums and
// counts sit in an internal memory of MAX_OUT_COLS entries, updated by a
// read-modify-write per sample; no clearing pass is needed after reset.
// Each sample is taken while its column entry is read, then written back;
// a sample that closes a block then loads its magnitude and divides on the
// shared bit-serial divider (quotient DV_W bits, 41 at the default
// parameters), skipped when no sample of the block was counted; the cell
// then waits in the output register while the next sample is taken, and
// a full output register waits for the sink. No sample is taken before
// the previous one is through. After any configuration write the block
// runs two divisions of the same unit (columns per row, block position)
// before it takes the next sample. The user must write configuration
// only while no sample is in flight; the block itself does not enforce this.

module block_average_downscaler
    import bavg_pkg::*;
#(
    parameter int MAX_OUT_COLS = 2048,
    parameter int MAX_FACTOR   = 16,
    parameter int SAMPLE_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [IN_W-1:0]      i_s_axis_tdata,   // sample
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]          o_m_axis_tdata,   // cell_value, out_col, out_row
    output logic                      o_m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    bavg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_axis_tvalid),
        .i_sts     (w_sts),
        .o_s_tready(o_s_axis_tready),
        .o_cmd     (w_cmd)
    );

    bavg_dp #(
        .MAX_OUT_COLS(MAX_OUT_COLS),
        .MAX_FACTOR  (MAX_FACTOR),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_s_tdata (i_s_axis_tdata),
        .i_m_tready(i_m_axis_tready),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_m_tvalid(o_m_axis_tvalid),
        .o_m_tdata (o_m_axis_tdata),
        .o_m_tlast (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

### bench/block_average_downscaler_tb.sv
`timescale 1ns / 100ps

module block_average_downscaler_tb;
    import bavg_pkg::*;

    localparam int          MAX_COLS     = 2048;
    localparam int          MAX_FCT      = 16;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          RANDOM_ITEMS = 350;
    localparam logic [31:0] SMP_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] SMP_MIN      = 32'h8000_0000;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              frame_end;
    } t_avg_cell;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = CFG_SCALE;
    logic [CFG_W-1:0]     i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // configuration as written, before saturation
    logic [FCT_W-1:0] cfg_factor = FCT_RST;
    logic [DIM_W-1:0] cfg_width  = WID_RST;
    logic [DIM_W-1:0] cfg_height = HGT_RST;
    logic [31:0]      cfg_fill   = '0;
    logic             cfg_ignore = 1'b0;
    logic             cfg_mask   = 1'b0;
    logic [31:0]      cfg_mval   = '0;

    longint      col_sum [MAX_COLS];
    int unsigned col_cnt [MAX_COLS];
    int unsigned src_col   = 0;
    int unsigned band_line = 0;
    int unsigned band_idx  = 0;

    logic [31:0] pending_samples [$];
    t_avg_cell   expected_cells [$];

    logic      in_taken    = 1'b0;
    int        gap_left    = 0;
    int        burst_left  = 0;
    int        stall_cyc   = 0;
    int        stall_mode  = 0;
    int        idle_cycles = 0;
    int        error_count = 0;
    t_avg_cell got_cell;
    t_avg_cell want_cell;

    block_average_downscaler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned eff_factor();
        if (cfg_factor < 2) return 2;
        if (cfg_factor > MAX_FCT) return MAX_FCT;
        return cfg_factor;
    endfunction

    function automatic int unsigned eff_width();
        if (cfg_width < 2) return 2;
        if (cfg_width > DIM_MAX) return DIM_MAX;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < 1) return 1;
        if (cfg_height > DIM_MAX) return DIM_MAX;
        return cfg_height;
    endfunction

    task automatic predict_sample(input logic [31:0] smp);
        int unsigned       f;
        int unsigned       w;
        int unsigned       h;
        int unsigned       ncols;
        int unsigned       oc;
        int unsigned       phase;
        int unsigned       n;
        longint            s;
        longint            v;
        longint unsigned   mag;
        longint unsigned   q;
        t_avg_cell         exp_c;
        f     = eff_factor();
        w     = eff_width();
        h     = eff_height();
        ncols = w / f;
        if (ncols > MAX_COLS) ncols = MAX_COLS;
        oc    = src_col / f;
        phase = src_col % f;
        s     = longint'($signed(smp));
        if (oc < ncols) begin
            if (band_line == 0 && phase == 0) begin
                col_sum[oc] = 0;
                col_cnt[oc] = 0;
            end
            if (!(cfg_ignore && s == longint'($signed(cfg_fill)))) begin
                if (cfg_mask) begin
                    v = (s == longint'($signed(cfg_mval))) ? PCT_FULL : 0;
                end else begin
                    v = s;
                end
                col_sum[oc] += v;
                col_cnt[oc] += 1;
            end
            if (band_line == f - 1 && phase == f - 1) begin
                n = col_cnt[oc];
                if (n != 0) begin
                    mag = (col_sum[oc] < 0) ? -col_sum[oc] : col_sum[oc];
                    q   = (2 * mag + n) / (2 * longint'(n));
                    v   = (col_sum[oc] < 0) ? -longint'(q) : longint'(q);
                    exp_c.value = v[CELL_W-1:0];
                end else if (cfg_mask) begin
                    exp_c.value = EMPTY_MASK;
                end else begin
                    exp_c.value = cfg_fill;
                end
                exp_c.col       = oc[OCOL_W-1:0];
                exp_c.row       = band_idx[OROW_W-1:0];
                exp_c.frame_end = (band_idx + 1 >= h) && (oc + 1 == ncols);
                expected_cells.push_back(exp_c);
            end
        end
        if (src_col + 1 >= w) begin
            src_col = 0;
            if (band_line + 1 >= f) begin
                band_line = 0;
                band_idx  = (band_idx + 1 >= h) ? 0 : band_idx + 1;
            end else begin
                band_line++;
            end
        end else begin
            src_col++;
        end
    endtask

    function automatic logic [31:0] noisy(input logic [31:0] val, input int width);
        logic [31:0] keep;
        keep = (32'h1 << width) - 32'h1;
        if ($urandom_range(0, 3) == 0) return ($urandom & ~keep) | (val & keep);
        return val;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return SMP_MIN;
            1: return SMP_MAX;
            2: return '0;
            3: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1: return cfg_fill;
            2: return cfg_mval;
            3: return pick_word();
            4, 5, 6: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SCALE:  cfg_factor = data[FCT_W-1:0];
            CFG_WIDTH:  cfg_width  = data[DIM_W-1:0];
            CFG_HEIGHT: cfg_height = data[DIM_W-1:0];
            CFG_FILL:   cfg_fill   = data;
            CFG_IGNORE: cfg_ignore = data[0];
            CFG_MASK:   cfg_mask   = data[0];
            CFG_MVAL:   cfg_mval   = data;
            default: ;
        endcase
    endtask

    // wait until every item is in and every cell is out, then let the block settle
    task automatic settle();
        @(posedge i_clk);
        while (pending_samples.size() != 0 || i_s_axis_tvalid || expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [31:0] f, input logic [31:0] w,
                               input logic [31:0] h, input logic [31:0] fill,
                               input logic [31:0] ign, input logic [31:0] msk,
                               input logic [31:0] mval);
        settle();
        write_reg(CFG_SCALE, noisy(f, FCT_W));
        write_reg(CFG_WIDTH, noisy(w, DIM_W));
        write_reg(CFG_HEIGHT, noisy(h, DIM_W));
        write_reg(CFG_FILL, fill);
        write_reg(CFG_IGNORE, noisy(ign, 1));
        write_reg(CFG_MASK, noisy(msk, 1));
        write_reg(CFG_MVAL, mval);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_bands(input int unsigned bands);
        repeat (bands * eff_width() * eff_factor()) pending_samples.push_back(draw_sample());
    endtask

    initial begin
        int unsigned random_count;
        int unsigned f_e;
        logic [31:0] f_reg;
        logic [31:0] w_reg;
        logic [31:0] h_reg;
        random_count = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // factor below range, right-edge column dropped, field extremes, rounding of -0.5
        reconfigure(32'd1, 32'd5, 32'd3, '0, '0, '0, '0);
        pending_samples = '{SMP_MAX, SMP_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFE, $urandom,
                            SMP_MAX, SMP_MAX, 32'd0, 32'd1, $urandom};
        // all samples skipped: fill value out; row counter beyond new height wraps
        reconfigure(32'd2, 32'd2, 32'd0, SMP_MIN, 32'd1, '0, '0);
        pending_samples = '{SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN};
        // mask mode: empty block, then 2 hits of 3 counted
        reconfigure(32'd2, 32'd0, 32'd1, 32'd5, 32'd1, 32'd1, 32'hFFFF_FFFF);
        pending_samples = '{32'd5, 32'd5, 32'd5, 32'd5,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd5};

        // largest factor, above range
        reconfigure(32'd31, 32'd33, 32'd8191, pick_word(), 32'($urandom_range(0, 1)),
                    32'($urandom_range(0, 1)), pick_word());
        queue_bands(1);

        while (random_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: f_e = $urandom_range(5, MAX_FCT);
                1: f_e = MAX_FCT;
                default: f_e = $urandom_range(2, 4);
            endcase
            f_reg = f_e;
            if (f_e == 2 && $urandom_range(0, 2) == 0) f_reg = $urandom_range(0, 1);
            if (f_e == MAX_FCT && $urandom_range(0, 1) == 0) f_reg = $urandom_range(17, 31);
            if ($urandom_range(0, 9) == 0) begin
                w_reg = $urandom_range(0, f_e - 1);
            end else begin
                w_reg = f_e * $urandom_range(1, (f_e > 4) ? 1 : 4) + $urandom_range(0, f_e - 1);
            end
            case ($urandom_range(0, 7))
                0: h_reg = 0;
                1: h_reg = $urandom_range(4096, 8191);
                default: h_reg = $urandom_range(1, 4);
            endcase
            reconfigure(f_reg, w_reg, h_reg, pick_word(), 32'($urandom_range(0, 1)),
                        32'($urandom_range(0, 1)), pick_word());
            queue_bands($urandom_range(1, 4));
            random_count += pending_samples.size();
        end

        settle();
        if (error_count == 0 && expected_cells.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left        <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pending_samples.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 200 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_axis_tready <= (stall_cyc % 7 < 2);
            default: i_m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) predict_sample(i_s_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_cell.value     = o_m_axis_tdata[CELL_W-1:0];
            got_cell.col       = o_m_axis_tdata[CELL_W +: OCOL_W];
            got_cell.row       = o_m_axis_tdata[CELL_W+OCOL_W +: OROW_W];
            got_cell.frame_end = o_m_axis_tlast;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected cell: value %0d col %0d row %0d last %0b", $time,
                         $signed(got_cell.value), got_cell.col, got_cell.row,
                         got_cell.frame_end);
                error_count++;
            end else begin
                want_cell = expected_cells.pop_front();
                if (got_cell.value !== want_cell.value) begin
                    $display("%0t: cell_value expected %0d, actual %0d", $time,
                             $signed(want_cell.value), $signed(got_cell.value));
                    error_count++;
                end
                if (got_cell.col !== want_cell.col) begin
                    $display("%0t: out_col expected %0d, actual %0d", $time,
                             want_cell.col, got_cell.col);
                    error_count++;
                end
                if (got_cell.row !== want_cell.row) begin
                    $display("%0t: out_row expected %0d, actual %0d", $time,
                             want_cell.row, got_cell.row);
                    error_count++;
                end
                if (got_cell.frame_end !== want_cell.frame_end) begin
                    $display("%0t: frame_end expected %0b, actual %0b", $time,
                             want_cell.frame_end, got_cell.frame_end);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
